FILE: hw/rtl/sce_pkg.sv
// Shared types, constants and table-building functions for the softmax
// cross-entropy loss unit. No dependencies.
package sce_pkg;

  localparam logic [15:0] MAX_ROWS   = 16'hFFFF;
  localparam logic [16:0] LOG2E_Q16  = 17'd94548;
  localparam logic [15:0] LN2_Q16    = 16'd45426;
  localparam logic [63:0] LN2_Q30    = 64'd744261118;
  localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
  localparam int          DIV_STEPS  = 48;
  localparam logic signed [15:0] LOGIT_MIN = 16'sh8000;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_WALK, S_DRAIN, S_LAB_RD, S_LAB_CAP, S_NORM_LD, S_NORM,
    S_LOG_LK, S_LN_MUL, S_ACC, S_ROW_END, S_DIV_LD, S_DIV, S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic row_chk;
    logic walk_rd;
    logic lab_rd;
    logic lab_cap;
    logic norm_ld;
    logic norm_step;
    logic log_lk;
    logic ln_mul;
    logic acc_add;
    logic row_done;
    logic div_ld;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic rows_full;
    logic row_bad;
    logic walk_last;
    logic pipe_empty;
    logic norm_done;
    logic div_last;
    logic out_free;
    logic batch_end;
  } sts_t;

  // 2^(-k/2^b) in Q.16 through a truncated Taylor series of exp in Q30.
  function automatic logic [16:0] pow2_neg(int unsigned k, int unsigned b);
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] s;
    t    = (64'(k) * LN2_Q30) >> b;
    term = ONE_Q30;
    s    = ONE_Q30;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * t) >> 30) / 64'(n);
      if (n % 2 == 1) s = s - term;
      else            s = s + term;
    end
    return 17'((s + 64'd8192) >> 14);
  endfunction

  // log2(1 + k/2^b), 16 fraction bits, by repeated squaring in Q30.
  function automatic logic [15:0] log2_frac(int unsigned k, int unsigned b);
    logic [63:0] x;
    logic [15:0] r;
    x = (64'(1 << b) + 64'(k)) << (30 - b);
    r = '0;
    for (int bb = 15; bb >= 0; bb--) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        r[bb] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/sce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sce_ram #(
  parameter int W = 16,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/sce_ctrl.sv
// Sequencer for the loss unit: steps each row end and batch end through
// the datapath. Depends on sce_pkg.
module sce_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_end,
  output logic          in_ready,
  input  sce_pkg::sts_t sts,
  output sce_pkg::cmd_t cmd
);
  sce_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sce_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sce_pkg::S_IDLE:    if (in_valid && in_end) state_nxt = sce_pkg::S_CHECK;
      sce_pkg::S_CHECK:   state_nxt = (sts.rows_full || sts.row_bad) ?
                                      sce_pkg::S_ROW_END : sce_pkg::S_WALK;
      sce_pkg::S_WALK:    if (sts.walk_last) state_nxt = sce_pkg::S_DRAIN;
      sce_pkg::S_DRAIN:   if (sts.pipe_empty) state_nxt = sce_pkg::S_LAB_RD;
      sce_pkg::S_LAB_RD:  state_nxt = sce_pkg::S_LAB_CAP;
      sce_pkg::S_LAB_CAP: state_nxt = sce_pkg::S_NORM_LD;
      sce_pkg::S_NORM_LD: state_nxt = sce_pkg::S_NORM;
      sce_pkg::S_NORM:    if (sts.norm_done) state_nxt = sce_pkg::S_LOG_LK;
      sce_pkg::S_LOG_LK:  state_nxt = sce_pkg::S_LN_MUL;
      sce_pkg::S_LN_MUL:  state_nxt = sce_pkg::S_ACC;
      sce_pkg::S_ACC:     state_nxt = sce_pkg::S_ROW_END;
      sce_pkg::S_ROW_END: state_nxt = sts.batch_end ? sce_pkg::S_DIV_LD : sce_pkg::S_IDLE;
      sce_pkg::S_DIV_LD:  state_nxt = sce_pkg::S_DIV;
      sce_pkg::S_DIV:     if (sts.div_last) state_nxt = sce_pkg::S_OUT;
      sce_pkg::S_OUT:     if (sts.out_free) state_nxt = sce_pkg::S_IDLE;
      default:            state_nxt = sce_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      sce_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      sce_pkg::S_CHECK:   cmd.row_chk   = 1'b1;
      sce_pkg::S_WALK:    cmd.walk_rd   = 1'b1;
      sce_pkg::S_DRAIN:   cmd           = '0;
      sce_pkg::S_LAB_RD:  cmd.lab_rd    = 1'b1;
      sce_pkg::S_LAB_CAP: cmd.lab_cap   = 1'b1;
      sce_pkg::S_NORM_LD: cmd.norm_ld   = 1'b1;
      sce_pkg::S_NORM:    cmd.norm_step = !sts.norm_done;
      sce_pkg::S_LOG_LK:  cmd.log_lk    = 1'b1;
      sce_pkg::S_LN_MUL:  cmd.ln_mul    = 1'b1;
      sce_pkg::S_ACC:     cmd.acc_add   = 1'b1;
      sce_pkg::S_ROW_END: cmd.row_done  = 1'b1;
      sce_pkg::S_DIV_LD:  cmd.div_ld    = 1'b1;
      sce_pkg::S_DIV:     cmd.div_step  = 1'b1;
      sce_pkg::S_OUT:     cmd.out_load  = sts.out_free;
      default:            cmd           = '0;
    endcase
  end
endmodule

FILE: hw/rtl/sce_dp.sv
// Datapath of the loss unit: row buffer, exp/log tables, accumulator,
// divider and output register. Depends on sce_pkg and sce_ram.
module sce_dp #(
  parameter int MAX_CLASSES    = 16,
  parameter int EXP_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [15:0] in_logit,
  input  logic [3:0]         in_label,
  input  logic               in_last_in_batch,
  input  sce_pkg::cmd_t      cmd,
  output sce_pkg::sts_t      sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [31:0]        out_mean_loss,
  output logic [15:0]        out_batch_rows,
  output logic               out_label_error
);
  localparam int AW = $clog2(MAX_CLASSES);
  localparam int CW = $clog2(MAX_CLASSES + 2);
  localparam int SW = 17 + $clog2(MAX_CLASSES);
  localparam int EW = $clog2(SW - 16);
  localparam int B  = EXP_TABLE_BITS;
  localparam int TN = 1 << EXP_TABLE_BITS;

  logic [16:0] exp_rom [TN];
  logic [15:0] log_rom [TN];

  for (genvar k = 0; k < TN; k++) begin : g_rom
    localparam logic [16:0] EV = sce_pkg::pow2_neg(k, B);
    localparam logic [15:0] LV = sce_pkg::log2_frac(k, B);
    assign exp_rom[k] = EV;
    assign log_rom[k] = LV;
  end

  logic [CW-1:0]      cnt_r;
  logic signed [15:0] max_r;
  logic [3:0]         label_r;
  logic               batch_r;
  logic [AW-1:0]      walk_idx_r;
  logic               v1_r, v2_r, v3_r;
  logic [22:0]        y_r;
  logic [6:0]         ip_r;
  logic [16:0]        exp_r;
  logic [SW-1:0]      sum_r;
  logic [15:0]        lab_diff_r;
  logic [SW-1:0]      norm_r;
  logic [EW-1:0]      e_r;
  logic [15:0]        logv_r;
  logic [EW+15:0]     ln_r;
  logic [47:0]        acc_r;
  logic [15:0]        rows_r;
  logic               err_r;
  logic [47:0]        q_r;
  logic [15:0]        rem_r;
  logic [5:0]         div_cnt_r;
  logic               out_valid_r;
  logic [31:0]        mean_r;
  logic [15:0]        brows_r;
  logic               berr_r;

  logic               wr_en;
  logic [15:0]        rd_data;
  logic [15:0]        diff;
  logic [32:0]        yprod;
  logic [16:0]        term;
  logic [EW+31:0]     lnprod;
  logic [48:0]        acc_sum;
  logic [16:0]        rsh;
  logic               qbit;
  logic [31:0]        mean_nxt;

  assign wr_en = cmd.accept && (cnt_r < CW'(MAX_CLASSES));

  sce_ram #(.W(16), .D(MAX_CLASSES)) u_buf (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_logit),
    .re    (cmd.walk_rd || cmd.lab_rd),
    .raddr (cmd.lab_rd ? AW'(label_r) : walk_idx_r),
    .rdata (rd_data)
  );

  always_comb begin
    diff    = max_r - rd_data;
    yprod   = 33'(diff) * 33'(sce_pkg::LOG2E_Q16);
    term    = (ip_r > 7'd16) ? 17'd0 : (exp_r >> ip_r);
    lnprod  = (EW+32)'({e_r, logv_r}) * (EW+32)'(sce_pkg::LN2_Q16) + (EW+32)'(32768);
    acc_sum = 49'(acc_r) + 49'({lab_diff_r, 6'b0}) + 49'(ln_r);
    rsh     = {rem_r, q_r[47]};
    qbit    = rsh >= {1'b0, rows_r};
    if (rows_r == '0)       mean_nxt = '0;
    else if (|q_r[47:32])   mean_nxt = 32'hFFFF_FFFF;
    else                    mean_nxt = q_r[31:0];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      max_r       <= sce_pkg::LOGIT_MIN;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      acc_r       <= '0;
      rows_r      <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (cnt_r < CW'(MAX_CLASSES) && in_logit > max_r) max_r <= in_logit;
        if (cnt_r <= CW'(MAX_CLASSES)) cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.row_done) begin
        cnt_r <= '0;
        max_r <= sce_pkg::LOGIT_MIN;
      end
      v1_r <= cmd.walk_rd;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.row_chk) begin
        if (sts.rows_full) err_r <= 1'b1;
        else begin
          rows_r <= rows_r + 16'd1;
          if (sts.row_bad) err_r <= 1'b1;
        end
      end
      if (cmd.acc_add) acc_r <= acc_sum[48] ? {48{1'b1}} : acc_sum[47:0];
      if (cmd.out_load) begin
        acc_r       <= '0;
        rows_r      <= '0;
        err_r       <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      label_r <= in_label;
      batch_r <= in_last_in_batch;
    end
    if (cmd.row_chk) begin
      walk_idx_r <= '0;
      sum_r      <= '0;
    end
    if (cmd.walk_rd) walk_idx_r <= walk_idx_r + AW'(1);
    if (v1_r) y_r <= yprod[32:10];
    if (v2_r) begin
      ip_r  <= y_r[22:16];
      exp_r <= exp_rom[y_r[15 -: B]];
    end
    if (v3_r) sum_r <= sum_r + SW'(term);
    if (cmd.lab_cap) lab_diff_r <= diff;
    if (cmd.norm_ld) begin
      norm_r <= (sum_r < SW'(65536)) ? SW'(65536) : sum_r;
      e_r    <= EW'(SW - 17);
    end
    if (cmd.norm_step) begin
      norm_r <= norm_r << 1;
      e_r    <= e_r - EW'(1);
    end
    if (cmd.log_lk) logv_r <= log_rom[norm_r[SW-2 -: B]];
    if (cmd.ln_mul) ln_r <= lnprod[EW+31:16];
    if (cmd.div_ld) begin
      q_r       <= acc_r;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      q_r       <= {q_r[46:0], qbit};
      rem_r     <= qbit ? 16'(rsh - {1'b0, rows_r}) : rsh[15:0];
      div_cnt_r <= div_cnt_r + 6'd1;
    end
    if (cmd.out_load) begin
      mean_r  <= mean_nxt;
      brows_r <= rows_r;
      berr_r  <= err_r;
    end
  end

  always_comb begin
    sts.rows_full  = rows_r >= sce_pkg::MAX_ROWS;
    sts.row_bad    = (cnt_r > CW'(MAX_CLASSES)) ||
                     ({{CW{1'b0}}, label_r} >= {4'b0, cnt_r});
    sts.walk_last  = CW'(walk_idx_r) == cnt_r - CW'(1);
    sts.pipe_empty = !(v1_r || v2_r || v3_r);
    sts.norm_done  = norm_r[SW-1];
    sts.div_last   = div_cnt_r == 6'(sce_pkg::DIV_STEPS - 1);
    sts.out_free   = !out_valid_r || out_ready;
    sts.batch_end  = batch_r;
  end

  assign out_valid       = out_valid_r;
  assign out_mean_loss   = mean_r;
  assign out_batch_rows  = brows_r;
  assign out_label_error = berr_r;
endmodule

FILE: hw/rtl/softmax_cross_entropy_loss_unit.sv
// Top level of the softmax cross-entropy loss unit: sequencer plus datapath.
// Depends on sce_pkg, sce_ctrl, sce_dp (and sce_ram through it).
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+----------------------
//   input   | in_logit, in_label, in_last_in_row,     | in_valid / in_ready
//           | in_last_in_batch                        |
//   result  | out_mean_loss, out_batch_rows,          | out_valid / out_ready
//           | out_label_error                         |
//
// Each logit is a one-cycle transaction while the row is open. A row end
// holds in_ready low while the row is checked, its N logits walk the exp
// table pipeline and the sum is normalised, looked up in the log table and
// accumulated. A batch end adds the bit-serial 48-step divider, plus any
// wait for the result register to drain. Synchronous reset (rst_n low)
// clears the row, the accumulator and the result valid; no clearing pass.
// A stalled result never blocks input until the next batch end.
module softmax_cross_entropy_loss_unit #(
  parameter int MAX_CLASSES    = 16,
  parameter int EXP_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_logit,
  input  logic [3:0]         in_label,
  input  logic               in_last_in_row,
  input  logic               in_last_in_batch,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_mean_loss,
  output logic [15:0]        out_batch_rows,
  output logic               out_label_error
);
  sce_pkg::cmd_t cmd;
  sce_pkg::sts_t sts;

  // Sequencer: owns the row/batch flow and the input handshake.
  sce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_end   (in_last_in_row || in_last_in_batch),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: buffer, tables, accumulator, divider, result register.
  sce_dp #(
    .MAX_CLASSES    (MAX_CLASSES),
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_logit         (in_logit),
    .in_label         (in_label),
    .in_last_in_batch (in_last_in_batch),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_mean_loss    (out_mean_loss),
    .out_batch_rows   (out_batch_rows),
    .out_label_error  (out_label_error)
  );

  // A row-ending transaction must close the input while the row is scored.
  a_row_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_last_in_row || in_last_in_batch)) |=> !in_ready)
    else $error("input still open after row end");

  // Every batch end closes at least one row.
  a_rows_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_batch_rows != 16'd0))
    else $error("result with zero rows");

  // Reset leaves the block idle with no pending result.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (in_ready && !out_valid))
    else $error("block not idle after reset");
endmodule
